/* hdl/sptg_pkg.sv */
// Shared types and constants for the SSTV pixel tone synthesizer.
`default_nettype none

package sptg_pkg;

  // Segment commands
  localparam logic [2:0] CMD_PORCH  = 3'd0;
  localparam logic [2:0] CMD_SYNC   = 3'd1;
  localparam logic [2:0] CMD_TONE   = 3'd2;
  localparam logic [2:0] CMD_PARITY = 3'd3;
  localparam logic [2:0] CMD_VIDEO  = 3'd4;

  // Video component codes
  localparam logic [2:0] COMP_RED      = 3'd0;
  localparam logic [2:0] COMP_GREEN    = 3'd1;
  localparam logic [2:0] COMP_BLUE     = 3'd2;
  localparam logic [2:0] COMP_LUMA_A   = 3'd3;
  localparam logic [2:0] COMP_LUMA_B   = 3'd4;
  localparam logic [2:0] COMP_CHROMA_R = 3'd5;
  localparam logic [2:0] COMP_CHROMA_B = 3'd6;

  // Tone frequencies in Hz, Q8
  localparam logic [19:0] FREQ_1200_Q8 = 20'd307200;
  localparam logic [19:0] FREQ_1500_Q8 = 20'd384000;
  localparam logic [19:0] FREQ_2300_Q8 = 20'd588800;
  localparam int unsigned SPAN_Q8      = 204800;

  localparam logic [19:0] STEP_RESET = 20'd89478;

  typedef struct packed {
    logic [19:0] freq;
    logic [7:0]  value;
  } sptg_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sptg_qstat_t;

endpackage

`default_nettype wire

/* hdl/sptg_req_if.sv */
// Input channel: one audio sample request with segment command and pixel pair.
`default_nettype none

interface sptg_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [11:0] tone_hz;
  logic       line_odd;
  logic [2:0] component;
  logic [7:0] pixel_a_red;
  logic [7:0] pixel_a_green;
  logic [7:0] pixel_a_blue;
  logic [7:0] pixel_b_red;
  logic [7:0] pixel_b_green;
  logic [7:0] pixel_b_blue;

  modport source (
    output valid, cmd, tone_hz, line_odd, component,
    output pixel_a_red, pixel_a_green, pixel_a_blue,
    output pixel_b_red, pixel_b_green, pixel_b_blue,
    input  ready
  );
  modport sink (
    input  valid, cmd, tone_hz, line_odd, component,
    input  pixel_a_red, pixel_a_green, pixel_a_blue,
    input  pixel_b_red, pixel_b_green, pixel_b_blue,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/sptg_rsp_if.sv */
// Output channel: one audio sample with its tone frequency and video value.
`default_nettype none

interface sptg_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] audio_sample;
  logic [19:0]        tone_freq_q8;
  logic [7:0]         component_value;

  modport source (
    output valid, audio_sample, tone_freq_q8, component_value,
    input  ready
  );
  modport sink (
    input  valid, audio_sample, tone_freq_q8, component_value,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/sptg_cfg_if.sv */
// Configuration write channel for the phase step register.
`default_nettype none

interface sptg_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/sptg_front.sv */
// Front end: accepts requests, computes the video component and tone frequency.
`default_nettype none

module sptg_front
  import sptg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sptg_req_if.sink   req,
  input  sptg_qstat_t qstat,
  output logic       push,
  output sptg_entry_t push_entry
);

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_LUMA   = 4'b0010,
    F_CHROMA = 4'b0100,
    F_PUSH   = 4'b1000
  } front_state_t;

  typedef logic [19:0] vfreq_t [256];

  // Video value to Q8 frequency, 1500 + v * 800 / 255 rounded
  function automatic vfreq_t build_vfreq();
    vfreq_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 20'(384000 + (i * SPAN_Q8 + 127) / 255);
    end
    return tab;
  endfunction

  localparam vfreq_t VIDEO_FREQ = build_vfreq();

  front_state_t state, state_next;

  logic [2:0]  cmd;
  logic [11:0] tone_hz;
  logic        line_odd;
  logic [2:0]  component;
  logic [7:0]  ar, ag, ab, br, bg, bb;
  logic [7:0]  ya, yb;
  logic [7:0]  value;

  logic [14:0] luma_num_a, luma_num_b;
  logic [27:0] luma_prod_a, luma_prod_b;
  logic [8:0]  y_sum;
  logic [8:0]  r_sum, b_sum;
  logic [12:0] cr_pos, cr_num;
  logic [11:0] cr_neg;
  logic [25:0] cr_prod;
  logic [15:0] cb_pos, cb_num;
  logic [14:0] cb_neg;
  logic [32:0] cb_prod;
  logic [7:0]  cr_val, cb_val;
  logic [7:0]  value_next;
  logic [19:0] freq_next;

  assign req.ready = (state == F_IDLE);
  assign push = (state == F_PUSH) && !qstat.full;
  // Frequency comes from the registered value during the push cycle
  assign push_entry = '{freq: freq_next, value: value};

  // Luma, divide by 100 through reciprocal 5243 / 2^19
  assign luma_num_a  = 15'(59 * ag) + 15'(30 * ar) + 15'(11 * ab);
  assign luma_num_b  = 15'(59 * bg) + 15'(30 * br) + 15'(11 * bb);
  assign luma_prod_a = 28'(luma_num_a) * 28'd5243;
  assign luma_prod_b = 28'(luma_num_b) * 28'd5243;

  // Chroma: clamp negative numerators to zero, divide, saturate at 255
  assign y_sum  = {1'b0, ya} + {1'b0, yb};
  assign r_sum  = {1'b0, ar} + {1'b0, br};
  assign b_sum  = {1'b0, ab} + {1'b0, bb};
  assign cr_pos = 13'(10 * r_sum[8:1]) + 13'd1785;
  assign cr_neg = 12'(5 * y_sum);
  assign cr_num = cr_pos - 13'(cr_neg);
  assign cr_prod = 26'(cr_num) * 26'd4682;
  assign cb_pos = 16'(100 * b_sum[8:1]) + 16'd22695;
  assign cb_neg = 15'(50 * y_sum);
  assign cb_num = cb_pos - 16'(cb_neg);
  assign cb_prod = 33'(cb_num) * 33'd94255;

  always_comb begin
    if (cr_pos < 13'(cr_neg)) begin
      cr_val = 8'd0;
    end else if (cr_prod[24:16] > 9'd255) begin
      cr_val = 8'd255;
    end else begin
      cr_val = cr_prod[23:16];
    end
    if (cb_pos < 16'(cb_neg)) begin
      cb_val = 8'd0;
    end else if (cb_prod[32:24] > 9'd255) begin
      cb_val = 8'd255;
    end else begin
      cb_val = cb_prod[31:24];
    end
  end

  always_comb begin
    value_next = 8'd0;
    if (cmd == CMD_VIDEO) begin
      case (component)
        COMP_RED:      value_next = ar;
        COMP_GREEN:    value_next = ag;
        COMP_BLUE:     value_next = ab;
        COMP_LUMA_A:   value_next = ya;
        COMP_LUMA_B:   value_next = yb;
        COMP_CHROMA_R: value_next = cr_val;
        COMP_CHROMA_B: value_next = cb_val;
        default:       value_next = ya;
      endcase
    end
  end

  always_comb begin
    case (cmd)
      CMD_SYNC:   freq_next = FREQ_1200_Q8;
      CMD_TONE:   freq_next = (tone_hz != 12'd0) ? {tone_hz, 8'd0} : FREQ_1500_Q8;
      CMD_PARITY: freq_next = line_odd ? FREQ_2300_Q8 : FREQ_1500_Q8;
      CMD_VIDEO:  freq_next = VIDEO_FREQ[value];
      default:    freq_next = FREQ_1500_Q8;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:   if (req.valid) state_next = F_LUMA;
      F_LUMA:   state_next = F_CHROMA;
      F_CHROMA: state_next = F_PUSH;
      F_PUSH:   if (!qstat.full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (req.valid) begin
          cmd       <= req.cmd;
          tone_hz   <= req.tone_hz;
          line_odd  <= req.line_odd;
          component <= req.component;
          ar        <= req.pixel_a_red;
          ag        <= req.pixel_a_green;
          ab        <= req.pixel_a_blue;
          br        <= req.pixel_b_red;
          bg        <= req.pixel_b_green;
          bb        <= req.pixel_b_blue;
        end
      end
      F_LUMA: begin
        ya <= luma_prod_a[26:19];
        yb <= luma_prod_b[26:19];
      end
      F_CHROMA: begin
        value <= value_next;
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/sptg_queue.sv */
// Two-entry queue between the front end and the tone back end.
`default_nettype none

module sptg_queue
  import sptg_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  sptg_entry_t push_entry,
  input  wire logic   pop,
  output sptg_entry_t pop_entry,
  output sptg_qstat_t qstat
);

  sptg_entry_t slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign pop_entry   = slots[rd_ptr];
  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/sptg_back.sv */
// Back end: phase accumulator, quarter-wave sine ROM and output register.
`default_nettype none

module sptg_back
  import sptg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 12
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic [19:0] step,
  input  sptg_qstat_t  qstat,
  input  sptg_entry_t  pop_entry,
  output logic         pop,
  sptg_rsp_if.source   rsp
);

  localparam int QBITS   = SINE_TABLE_BITS - 2;
  localparam int QUARTER = 1 << QBITS;
  localparam int IDX_W   = QBITS + 1;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] AMPLITUDE   = 64'd18022;

  typedef logic [14:0] rom_t [QUARTER + 1];

  // Sine magnitude for quarter-wave points 0..QUARTER, Taylor series in Q30
  function automatic rom_t build_rom();
    rom_t tab;
    logic [63:0] x, x2, t, s, mag;
    for (int i = 0; i <= QUARTER; i++) begin
      x   = (HALF_PI_Q30 * 64'(i)) >> QBITS;
      x2  = (x * x) >> 30;
      t   = ONE_Q30 - ((x2 * ONE_Q30) >> 30) / 110;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s   = (x * t) >> 30;
      mag = (s * AMPLITUDE + 64'd536870912) >> 30;
      if (mag > AMPLITUDE) mag = AMPLITUDE;
      tab[i] = 15'(mag);
    end
    return tab;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_OUT  = 3'b100
  } back_state_t;

  back_state_t state, state_next;

  logic [31:0]               phase;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [IDX_W-1:0]          idx;
  logic [14:0]               rom_q;
  logic                      neg;
  logic [39:0]               prod;
  logic [39:0]               inc;
  logic [19:0]               freq;
  logic [7:0]                value;
  logic signed [15:0]        sample;
  logic                      out_load;

  assign k   = phase[31 -: SINE_TABLE_BITS];
  assign idx = k[QBITS] ? IDX_W'(QUARTER) - {1'b0, k[QBITS-1:0]} : {1'b0, k[QBITS-1:0]};
  assign inc = prod + 40'd128;
  assign sample = neg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  assign pop      = (state == B_IDLE) && !qstat.empty;
  assign out_load = (state == B_OUT) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!qstat.empty) state_next = B_MUL;
      B_MUL:   state_next = B_OUT;
      B_OUT:   if (out_load) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rom_q <= SINE_ROM[idx];
      neg   <= k[QBITS+1];
      prod  <= 40'(step) * 40'(pop_entry.freq);
      freq  <= pop_entry.freq;
      value <= pop_entry.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      phase     <= 32'd0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      // Advance by the rounded step; the sample already holds the old phase
      if (state == B_MUL) begin
        phase <= phase + inc[39:8];
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.audio_sample    <= sample;
      rsp.tone_freq_q8    <= freq;
      rsp.component_value <= value;
    end
  end

endmodule

`default_nettype wire

/* hdl/sstv_pixel_tone_synthesizer_core.sv */
// Top level of the SSTV pixel tone synthesizer.
//
//   channel  dir  transaction
//   cfg      in   phase step per Hz (20 bit), written when valid && ready
//   req      in   command, tone, parity, component and two RGB pixels
//   rsp      out  audio sample, tone frequency Q8, video component value
//
// The front end steps through capture, luma, chroma and frequency per request and
// takes no new one until the queue has room; the back end steps through ROM read
// and step multiply, phase add and output load. A two-entry queue sits between them.
// Synchronous reset clears the phase to zero and the step to 89478.
// A stalled rsp holds its register; the back end, the queue and the front end
// then fill up and req.ready drops.
`default_nettype none

module sstv_pixel_tone_synthesizer_core
  import sptg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 12
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sptg_cfg_if.sink   cfg,
  sptg_req_if.sink   req,
  sptg_rsp_if.source rsp
);

  logic [19:0] step;
  sptg_qstat_t qstat;
  sptg_entry_t push_entry, pop_entry;
  logic        push, pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (cfg.valid) begin
      step <= cfg.data;
    end
  end

  sptg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  sptg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  sptg_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .qstat     (qstat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the SSTV pixel tone synthesizer core.
`default_nettype none

module tb import sptg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SINE_BITS   = 12;
  localparam int QBITS       = SINE_BITS - 2;
  localparam int QUARTER     = 1 << QBITS;
  localparam int CLK_PERIOD  = 8;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;

  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned AMPLITUDE   = 64'd18022;
  localparam logic [19:0]     STEP_ALL_ONES = 20'hFFFFF;
  localparam logic [19:0]     STEP_8KHZ     = 20'd536871;

  typedef struct {
    logic [2:0]  cmd;
    logic [11:0] tone_hz;
    logic        line_odd;
    logic [2:0]  component;
    logic [7:0]  ar, ag, ab, br, bg, bb;
  } tone_req_t;

  typedef struct packed {
    logic signed [15:0] audio;
    logic [19:0]        freq;
    logic [7:0]         value;
  } sample_t;

  logic clk = 1'b0;
  logic rst;

  sptg_cfg_if cfg_ch ();
  sptg_req_if req_ch ();
  sptg_rsp_if rsp_ch ();

  sstv_pixel_tone_synthesizer_core #(.SINE_TABLE_BITS(SINE_BITS)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic [31:0] phase_acc;
  logic [19:0] step_per_hz;
  sample_t     expected_samples[$];

  int mismatch_count    = 0;
  bit idle_enable       = 1'b1;
  bit long_hold_pending = 1'b0;
  int hold_left         = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic longint unsigned q30_mul(input longint unsigned a, input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Quadrant-folded Taylor sine scaled to the output amplitude
  function automatic logic signed [15:0] sine_amplitude(input logic [SINE_BITS-1:0] k);
    int unsigned        quad, rem;
    longint unsigned    x, x2, t, s, mag;
    logic signed [15:0] m;
    quad = k >> QBITS;
    rem = k & (QUARTER - 1);
    if ((quad & 1) != 0) rem = QUARTER - rem;
    x = (HALF_PI_Q30 * rem) >> QBITS;
    x2 = q30_mul(x, x);
    t = ONE_Q30 - q30_mul(x2, ONE_Q30) / 110;
    t = ONE_Q30 - q30_mul(x2, t) / 72;
    t = ONE_Q30 - q30_mul(x2, t) / 42;
    t = ONE_Q30 - q30_mul(x2, t) / 20;
    t = ONE_Q30 - q30_mul(x2, t) / 6;
    s = q30_mul(x, t);
    mag = (s * AMPLITUDE + (64'd1 << 29)) >> 30;
    if (mag > AMPLITUDE) mag = AMPLITUDE;
    m = mag[15:0];
    return ((quad & 2) != 0) ? -m : m;
  endfunction

  function automatic int luma(input int r, input int g, input int b);
    return (59 * g + 30 * r + 11 * b) / 100;
  endfunction

  function automatic int unsigned chroma_clamp(input int num, input int den);
    int v;
    if (num < 0) return 0;
    v = num / den;
    return (v > 255) ? 255 : v;
  endfunction

  // Produce the sample for one request and advance the phase
  function automatic sample_t synthesize_sample(input tone_req_t r);
    sample_t         s;
    int              ya, yb;
    int unsigned     freq, value;
    longint unsigned inc;
    freq = FREQ_1500_Q8;
    value = 0;
    case (r.cmd)
      CMD_SYNC:   freq = FREQ_1200_Q8;
      CMD_TONE:   freq = (r.tone_hz != 0) ? {r.tone_hz, 8'd0} : FREQ_1500_Q8;
      CMD_PARITY: freq = r.line_odd ? FREQ_2300_Q8 : FREQ_1500_Q8;
      CMD_VIDEO: begin
        ya = luma(r.ar, r.ag, r.ab);
        yb = luma(r.br, r.bg, r.bb);
        case (r.component)
          COMP_RED:      value = r.ar;
          COMP_GREEN:    value = r.ag;
          COMP_BLUE:     value = r.ab;
          COMP_LUMA_B:   value = yb;
          COMP_CHROMA_R: value = chroma_clamp(
              10 * ((int'(r.ar) + int'(r.br)) / 2) - 5 * (ya + yb) + 1785, 14);
          COMP_CHROMA_B: value = chroma_clamp(
              100 * ((int'(r.ab) + int'(r.bb)) / 2) - 50 * (ya + yb) + 22695, 178);
          default:       value = ya;
        endcase
        freq = FREQ_1500_Q8 + (value * SPAN_Q8 + 127) / 255;
      end
      default: ;
    endcase
    s.audio = sine_amplitude(phase_acc[31 -: SINE_BITS]);
    inc = (64'(step_per_hz) * 64'(freq) + 64'd128) >> 8;
    phase_acc = phase_acc + inc[31:0];
    s.freq = freq[19:0];
    s.value = value[7:0];
    return s;
  endfunction

  // Check results, track the step register and queue predictions
  always @(posedge clk) begin : scoreboard
    sample_t   want;
    tone_req_t r;
    if (rst) begin
      phase_acc = '0;
      step_per_hz = STEP_RESET;
      expected_samples.delete();
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample with none expected");
        end else begin
          want = expected_samples.pop_front();
          if (rsp_ch.audio_sample !== want.audio)
            report_mismatch($sformatf("audio_sample got %0d expected %0d",
                                      rsp_ch.audio_sample, want.audio));
          if (rsp_ch.tone_freq_q8 !== want.freq)
            report_mismatch($sformatf("tone_freq_q8 got %0d expected %0d",
                                      rsp_ch.tone_freq_q8, want.freq));
          if (rsp_ch.component_value !== want.value)
            report_mismatch($sformatf("component_value got %0d expected %0d",
                                      rsp_ch.component_value, want.value));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) step_per_hz = cfg_ch.data;
      if (req_ch.valid && req_ch.ready) begin
        r.cmd = req_ch.cmd;
        r.tone_hz = req_ch.tone_hz;
        r.line_odd = req_ch.line_odd;
        r.component = req_ch.component;
        r.ar = req_ch.pixel_a_red;
        r.ag = req_ch.pixel_a_green;
        r.ab = req_ch.pixel_a_blue;
        r.br = req_ch.pixel_b_red;
        r.bg = req_ch.pixel_b_green;
        r.bb = req_ch.pixel_b_blue;
        expected_samples.push_back(synthesize_sample(r));
      end
    end
  end

  // Receiver pacing: random stall bursts plus one requested long hold
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      hold_left <= LONG_HOLD - 1;
      rsp_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 16);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without a transaction", QUIET_LIMIT);
    $display("tb failed");
    $finish;
  end

  function automatic logic [7:0] pixel_value();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic tone_req_t make_req(input logic [2:0] cmd, input logic [11:0] tone,
                                         input logic odd, input logic [2:0] comp,
                                         input int ar, ag, ab, br, bg, bb);
    tone_req_t r;
    r.cmd = cmd;
    r.tone_hz = tone;
    r.line_odd = odd;
    r.component = comp;
    r.ar = 8'(ar);
    r.ag = 8'(ag);
    r.ab = 8'(ab);
    r.br = 8'(br);
    r.bg = 8'(bg);
    r.bb = 8'(bb);
    return r;
  endfunction

  function automatic tone_req_t random_req();
    tone_req_t r;
    r.cmd = ($urandom_range(0, 1) == 0) ? CMD_VIDEO : 3'($urandom_range(0, 7));
    r.tone_hz = ($urandom_range(0, 15) == 0) ? 12'd0 : 12'($urandom());
    r.line_odd = 1'($urandom());
    r.component = 3'($urandom());
    r.ar = pixel_value();
    r.ag = pixel_value();
    r.ab = pixel_value();
    r.br = pixel_value();
    r.bg = pixel_value();
    r.bb = pixel_value();
    return r;
  endfunction

  // Offer one request and hold it until the transaction completes
  task automatic send_tone_req(input tone_req_t r);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_ch.cmd <= r.cmd;
    req_ch.tone_hz <= r.tone_hz;
    req_ch.line_odd <= r.line_odd;
    req_ch.component <= r.component;
    req_ch.pixel_a_red <= r.ar;
    req_ch.pixel_a_green <= r.ag;
    req_ch.pixel_a_blue <= r.ab;
    req_ch.pixel_b_red <= r.br;
    req_ch.pixel_b_green <= r.bg;
    req_ch.pixel_b_blue <= r.bb;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait for every predicted sample to come out
  task automatic drain_samples();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  task automatic write_step(input logic [19:0] step);
    cfg_ch.data <= step;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [19:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 20'd1;
      1:       return STEP_ALL_ONES;
      2:       return STEP_8KHZ;
      3:       return STEP_RESET;
      4:       return 20'($urandom_range(0, STEP_ALL_ONES));
      default: return 20'($urandom_range(1, 2000));
    endcase
  endfunction

  // Every command, field extremes and chroma clamps at the reset step
  task automatic test_directed();
    send_tone_req(make_req(CMD_PORCH, 12'd0, 1'b0, COMP_RED, 0, 0, 0, 0, 0, 0));
    send_tone_req(make_req(CMD_SYNC, 12'hFFF, 1'b1, 3'(COMP_CHROMA_B + 1),
                           255, 255, 255, 255, 255, 255));
    send_tone_req(make_req(CMD_TONE, 12'd0, 1'b0, COMP_RED, 0, 0, 0, 0, 0, 0));
    send_tone_req(make_req(CMD_TONE, 12'hFFF, 1'b0, COMP_RED, 0, 0, 0, 0, 0, 0));
    send_tone_req(make_req(CMD_TONE, 12'd1, 1'b1, COMP_RED, 0, 0, 0, 0, 0, 0));
    send_tone_req(make_req(CMD_PARITY, 12'd0, 1'b0, COMP_RED, 0, 0, 0, 0, 0, 0));
    send_tone_req(make_req(CMD_PARITY, 12'd0, 1'b1, COMP_RED, 0, 0, 0, 0, 0, 0));
    for (int c = COMP_RED; c <= COMP_CHROMA_B + 1; c++)
      send_tone_req(make_req(CMD_VIDEO, 12'd0, 1'b0, 3'(c), 255, 128, 0, 0, 64, 255));
    send_tone_req(make_req(CMD_VIDEO, 12'd0, 1'b0, COMP_CHROMA_R, 255, 0, 0, 255, 0, 0));
    send_tone_req(make_req(CMD_VIDEO, 12'd0, 1'b0, COMP_CHROMA_R, 0, 255, 255, 0, 255, 255));
    send_tone_req(make_req(CMD_VIDEO, 12'd0, 1'b0, COMP_CHROMA_B, 0, 0, 255, 0, 0, 255));
    send_tone_req(make_req(CMD_VIDEO, 12'd0, 1'b0, COMP_CHROMA_B, 255, 255, 0, 255, 255, 0));
    send_tone_req(make_req(CMD_VIDEO, 12'd0, 1'b0, COMP_LUMA_A, 0, 0, 0, 0, 0, 0));
    send_tone_req(make_req(CMD_VIDEO, 12'd0, 1'b0, COMP_LUMA_B, 255, 255, 255, 255, 255, 255));
    for (int c = CMD_VIDEO + 1; c < 8; c++)
      send_tone_req(make_req(3'(c), 12'd2000, 1'b1, COMP_GREEN, 9, 99, 199, 29, 129, 229));
  endtask

  // Minimum, maximum, zero and nominal step settings
  task automatic test_step_extremes();
    logic [19:0] steps[5];
    steps = '{20'd1, STEP_ALL_ONES, STEP_8KHZ, 20'd0, STEP_RESET};
    foreach (steps[i]) begin
      drain_samples();
      write_step(steps[i]);
      repeat (10) send_tone_req(random_req());
    end
  endtask

  // Hold the output long enough for the input to back up
  task automatic test_backpressure();
    drain_samples();
    idle_enable = 1'b0;
    long_hold_pending = 1'b1;
    repeat (24) send_tone_req(random_req());
    drain_samples();
    idle_enable = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (8) send_tone_req(random_req());
      drain_samples();
    end
  endtask

  task automatic test_random_mix();
    repeat (11) begin
      drain_samples();
      write_step(pick_step());
      repeat (160) send_tone_req(random_req());
    end
  endtask

  task automatic test_steady_stream();
    idle_enable = 1'b0;
    drain_samples();
    write_step(STEP_RESET);
    repeat (60) send_tone_req(random_req());
  endtask

  initial begin
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CMD_PORCH;
    req_ch.tone_hz <= '0;
    req_ch.line_odd <= 1'b0;
    req_ch.component <= COMP_RED;
    req_ch.pixel_a_red <= '0;
    req_ch.pixel_a_green <= '0;
    req_ch.pixel_a_blue <= '0;
    req_ch.pixel_b_red <= '0;
    req_ch.pixel_b_green <= '0;
    req_ch.pixel_b_blue <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_step_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_mix();
    test_steady_stream();

    drain_samples();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
